/* rtl/core/tile_aware_cache_tag_model_top_macros.svh */
// Assertion helpers for the tag store.
`ifndef TILE_AWARE_CACHE_TAG_MODEL_TOP_MACROS_SVH
`define TILE_AWARE_CACHE_TAG_MODEL_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TACT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define TACT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tact_pkg.sv */
package tact_pkg;

  // Default geometry.
  localparam int unsigned NumWaysDef = 8;
  localparam int unsigned NumSetsDef = 1024;
  localparam int unsigned LineBytesDef = 64;
  localparam int unsigned TileBytesDef = 4096;

  // Fixed field widths.
  localparam int unsigned AddrW = 64;
  localparam int unsigned TagW = 48;
  localparam int unsigned TileW = 32;
  localparam int unsigned StampW = 32;
  localparam int unsigned CntW = 64;
  localparam int unsigned WayOutW = 3;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WRITE = 3'b100
  } back_state_t;

endpackage

/* rtl/core/tact_front.sv */
// Front end: takes accesses, splits the address into set, tag and tile,
// and holds them in a two-entry queue for the back end.
module tact_front #(
  parameter int unsigned NUM_SETS = tact_pkg::NumSetsDef,
  parameter int unsigned LINE_BYTES = tact_pkg::LineBytesDef,
  parameter int unsigned TILE_BYTES = tact_pkg::TileBytesDef,
  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tact_pkg::AddrW-1:0]  in_address,
  input  logic                        in_is_write,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [SetW-1:0]             q_set,
  output logic [tact_pkg::TagW-1:0]   q_tag,
  output logic [tact_pkg::TileW-1:0]  q_tile,
  output logic                        q_write
);

  localparam int unsigned LineSh = $clog2(LINE_BYTES);
  localparam int unsigned SetSh = $clog2(NUM_SETS);
  localparam int unsigned TileSh = $clog2(TILE_BYTES);
  localparam int unsigned EntW = SetW + tact_pkg::TagW + tact_pkg::TileW + 1;

  logic [tact_pkg::AddrW-1:0] line_addr;
  logic [tact_pkg::AddrW-1:0] tag_full;
  logic [tact_pkg::AddrW-1:0] tile_full;
  logic [SetW-1:0]            set_idx;
  logic [EntW-1:0]            ent_in;
  logic [EntW-1:0]            ent_r [2];
  logic [1:0]                 cnt_r;
  logic [1:0]                 cnt_nxt;
  logic                       rd_r;
  logic                       rd_nxt;
  logic                       wr_ptr;
  logic                       push;
  logic                       pop;

  // Address classification; geometry is a power of two, so shifts suffice.
  always_comb begin
    line_addr = in_address >> LineSh;
    tag_full = line_addr >> SetSh;
    tile_full = in_address >> TileSh;
    if (NUM_SETS > 1) begin
      set_idx = line_addr[SetW-1:0];
    end else begin
      set_idx = '0;
    end
  end

  assign ent_in = {set_idx, tag_full[tact_pkg::TagW-1:0],
                   tile_full[tact_pkg::TileW-1:0], in_is_write};

  // Queue control.
  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign wr_ptr = rd_r ^ cnt_r[0];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  assign rd_nxt = pop ? ~rd_r : rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr] <= ent_in;
    end
  end

  assign {q_set, q_tag, q_tile, q_write} = ent_r[rd_r];

endmodule

/* rtl/core/tact_back.sv */
// Back end: reads the set, resolves hit or victim, writes the line back,
// and presents the result in an output register.
module tact_back #(
  parameter int unsigned NUM_WAYS = tact_pkg::NumWaysDef,
  parameter int unsigned NUM_SETS = tact_pkg::NumSetsDef,
  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int unsigned WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [SetW-1:0]             q_set,
  input  logic [tact_pkg::TagW-1:0]   q_tag,
  input  logic [tact_pkg::TileW-1:0]  q_tile,
  input  logic                        q_write,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [tact_pkg::WayOutW-1:0] out_way,
  output logic [tact_pkg::CntW-1:0]   out_hit_total,
  output logic [tact_pkg::CntW-1:0]   out_miss_total
);

  `include "tile_aware_cache_tag_model_top_macros.svh"

  localparam int unsigned LineW = 1 + 1 + tact_pkg::TagW + tact_pkg::StampW
                                  + tact_pkg::TileW;
  localparam int unsigned RowW = LineW * NUM_WAYS;

  typedef struct packed {
    logic                       valid;
    logic                       dirty;
    logic [tact_pkg::TagW-1:0]  tag;
    logic [tact_pkg::StampW-1:0] stamp;
    logic [tact_pkg::TileW-1:0] tile;
  } line_t;

  // One row of the tag memory holds all ways of a set.
  logic [RowW-1:0] mem [NUM_SETS];
  logic [RowW-1:0] rdata_r;

  tact_pkg::back_state_t st_r, st_nxt;
  logic [SetW:0]               clr_r;
  logic [SetW-1:0]             set_r;
  logic [tact_pkg::TagW-1:0]   tag_r;
  logic [tact_pkg::TileW-1:0]  tile_r;
  logic                        write_r;
  logic [tact_pkg::StampW-1:0] clock_r;
  logic [tact_pkg::CntW-1:0]   hits_r;
  logic [tact_pkg::CntW-1:0]   misses_r;
  logic                        ovalid_r;
  logic                        ohit_r;
  logic [tact_pkg::WayOutW-1:0] oway_r;

  line_t                       lines [NUM_WAYS];
  logic                        hit;
  logic [WayW-1:0]             hit_way;
  logic [WayW-1:0]             vic_way;
  logic [WayW-1:0]             sel_way;
  logic                        found_inv;
  logic                        best_other;
  logic [tact_pkg::StampW-1:0] best_age;
  logic                        other;
  logic [tact_pkg::StampW-1:0] age;
  logic [RowW-1:0]             wdata;
  line_t                       upd;
  logic                        take;
  logic                        mem_we;
  logic [SetW-1:0]             mem_waddr;

  // Accept from the queue only when idle and the output can be refilled.
  assign take = (st_r == tact_pkg::ST_IDLE) && q_valid && (!ovalid_r || out_ready);
  assign q_ready = take;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      lines[w] = rdata_r[w*LineW +: LineW];
    end
  end

  // Hit search and victim choice over the ways of the read row.
  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    vic_way = '0;
    found_inv = 1'b0;
    best_other = 1'b0;
    best_age = '0;
    other = 1'b0;
    age = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (lines[w].valid && lines[w].tag == tag_r) begin
        hit = 1'b1;
        hit_way = WayW'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      other = (lines[w].tile != tile_r);
      age = clock_r - lines[w].stamp;
      if (!found_inv) begin
        if (!lines[w].valid) begin
          found_inv = 1'b1;
          vic_way = WayW'(w);
        end else if (w == 0 || (other && !best_other) ||
                     (other == best_other && age > best_age)) begin
          vic_way = WayW'(w);
          best_other = other;
          best_age = age;
        end
      end
    end
    sel_way = hit ? hit_way : vic_way;
  end

  // Updated line and write data.
  always_comb begin
    upd = lines[sel_way];
    upd.stamp = clock_r;
    upd.tile = tile_r;
    if (hit) begin
      upd.dirty = lines[sel_way].dirty | write_r;
    end else begin
      upd.valid = 1'b1;
      upd.dirty = write_r;
      upd.tag = tag_r;
    end
    wdata = rdata_r;
    wdata[sel_way*LineW +: LineW] = upd;
    if (st_r == tact_pkg::ST_CLEAR) begin
      wdata = '0;
    end
  end

  assign mem_we = (st_r == tact_pkg::ST_CLEAR) || (st_r == tact_pkg::ST_WRITE);
  assign mem_waddr = (st_r == tact_pkg::ST_CLEAR) ? clr_r[SetW-1:0] : set_r;

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wdata;
    end
    if (take) begin
      rdata_r <= mem[q_set];
    end
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tact_pkg::ST_CLEAR: begin
        if (clr_r == (SetW+1)'(NUM_SETS - 1)) begin
          st_nxt = tact_pkg::ST_IDLE;
        end
      end
      tact_pkg::ST_IDLE: begin
        if (take) begin
          st_nxt = tact_pkg::ST_WRITE;
        end
      end
      tact_pkg::ST_WRITE: begin
        st_nxt = tact_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = tact_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tact_pkg::ST_CLEAR;
      clr_r <= '0;
      clock_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == tact_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (st_r == tact_pkg::ST_WRITE) begin
        clock_r <= clock_r + 1'b1;
        if (hit) begin
          hits_r <= hits_r + 1'b1;
        end else begin
          misses_r <= misses_r + 1'b1;
        end
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Access fields and result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      set_r <= q_set;
      tag_r <= q_tag;
      tile_r <= q_tile;
      write_r <= q_write;
    end
    if (st_r == tact_pkg::ST_WRITE) begin
      ohit_r <= hit;
      oway_r <= tact_pkg::WayOutW'({{tact_pkg::WayOutW{1'b0}}, sel_way});
    end
  end

  assign out_valid = ovalid_r;
  assign out_hit = ohit_r;
  assign out_way = oway_r;
  assign out_hit_total = hits_r;
  assign out_miss_total = misses_r;

  `TACT_ASSERT_NXT(a_take_write, take, st_r == tact_pkg::ST_WRITE,
                   "access taken but no write-back followed")
  `TACT_ASSERT_NXT(a_write_out, st_r == tact_pkg::ST_WRITE, ovalid_r,
                   "write-back without a result")
  `TACT_ASSERT_IMP(a_no_take_clear, st_r == tact_pkg::ST_CLEAR, !q_ready,
                   "access taken during clearing")
  `TACT_ASSERT_NXT(a_one_count, st_r == tact_pkg::ST_WRITE,
                   (hits_r != $past(hits_r)) != (misses_r != $past(misses_r)),
                   "exactly one total must advance per access")

endmodule

/* rtl/core/tile_aware_cache_tag_model_top.sv */
// Set-associative tag store with tile-aware replacement. In the back end each
// access first reads every way of the set from the tag memory (one row per
// set), then writes the updated row back; the back end takes no new access
// before that write-back. A two-entry queue in front accepts accesses while
// the back end is busy. After reset the block clears the tag memory one set
// per cycle, and the back end takes no access from the queue meanwhile.
// NUM_SETS, LINE_BYTES and TILE_BYTES must be powers of two.
module tile_aware_cache_tag_model_top #(
  parameter int unsigned NUM_WAYS = tact_pkg::NumWaysDef,
  parameter int unsigned NUM_SETS = tact_pkg::NumSetsDef,
  parameter int unsigned LINE_BYTES = tact_pkg::LineBytesDef,
  parameter int unsigned TILE_BYTES = tact_pkg::TileBytesDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tact_pkg::AddrW-1:0]   in_address,
  input  logic                         in_is_write,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [tact_pkg::WayOutW-1:0] out_way,
  output logic [tact_pkg::CntW-1:0]    out_hit_total,
  output logic [tact_pkg::CntW-1:0]    out_miss_total
);

  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  logic                       q_valid;
  logic                       q_ready;
  logic [SetW-1:0]            q_set;
  logic [tact_pkg::TagW-1:0]  q_tag;
  logic [tact_pkg::TileW-1:0] q_tile;
  logic                       q_write;

  tact_front #(
    .NUM_SETS(NUM_SETS), .LINE_BYTES(LINE_BYTES), .TILE_BYTES(TILE_BYTES)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_address, .in_is_write,
    .q_valid, .q_ready, .q_set, .q_tag, .q_tile, .q_write
  );

  tact_back #(
    .NUM_WAYS(NUM_WAYS), .NUM_SETS(NUM_SETS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_set, .q_tag, .q_tile, .q_write,
    .out_valid, .out_ready, .out_hit, .out_way, .out_hit_total, .out_miss_total
  );

endmodule

/* tb/tile_aware_cache_tag_model_top_test.sv */
module tile_aware_cache_tag_model_top_test;
  import tact_pkg::*;

  localparam int unsigned Ways = NumWaysDef;
  localparam int unsigned Sets = NumSetsDef;
  localparam int unsigned LineB = LineBytesDef;
  localparam int unsigned TileB = TileBytesDef;
  localparam int unsigned SetW = $clog2(Sets);
  localparam int unsigned OffW = $clog2(LineB);
  localparam int unsigned TileShift = $clog2(TileB);

  typedef struct packed {
    logic               hit;
    logic [WayOutW-1:0] way;
    logic [CntW-1:0]    hit_total;
    logic [CntW-1:0]    miss_total;
  } lookup_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [AddrW-1:0] in_address;
  logic in_is_write;
  logic out_valid;
  logic out_ready;
  logic out_hit;
  logic [WayOutW-1:0] out_way;
  logic [CntW-1:0] out_hit_total;
  logic [CntW-1:0] out_miss_total;

  tile_aware_cache_tag_model_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_address(in_address), .in_is_write(in_is_write),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_way(out_way),
    .out_hit_total(out_hit_total), .out_miss_total(out_miss_total)
  );

  // Shadow copy of the tag store.
  logic              shadow_valid [Sets*Ways];
  logic              shadow_dirty [Sets*Ways];
  logic [TagW-1:0]   shadow_tag [Sets*Ways];
  logic [StampW-1:0] shadow_use [Sets*Ways];
  logic [TileW-1:0]  shadow_tile [Sets*Ways];
  logic [StampW-1:0] use_stamp;
  logic [CntW-1:0]   hits_seen;
  logic [CntW-1:0]   misses_seen;

  lookup_t pending_lookups[$];
  int unsigned errors;
  int unsigned idle_pct;
  bit hold_out;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Compute the expected lookup outcome and update the shadow store.
  function automatic lookup_t predict_lookup(logic [AddrW-1:0] addr, logic wr);
    int unsigned set_idx;
    logic [TagW-1:0] tag;
    logic [TileW-1:0] tile;
    int unsigned base;
    int unsigned way;
    int unsigned idx;
    bit found;
    bit have;
    bit best_other;
    bit other;
    logic [StampW-1:0] best_age;
    logic [StampW-1:0] age;
    lookup_t r;
    set_idx = 32'((addr >> OffW) % Sets);
    tag = TagW'(addr >> (OffW + SetW));
    tile = TileW'(addr >> TileShift);
    base = set_idx * Ways;
    found = 0;
    way = 0;
    for (int w = 0; w < Ways; w++) begin
      if (!found && shadow_valid[base+w] && shadow_tag[base+w] == tag) begin
        found = 1;
        way = w;
      end
    end
    if (found) begin
      idx = base + way;
      hits_seen++;
      shadow_use[idx] = use_stamp;
      shadow_tile[idx] = tile;
      if (wr) shadow_dirty[idx] = 1;
    end else begin
      // Victim: first invalid way, else other tile first, then oldest.
      have = 0;
      best_other = 0;
      best_age = 0;
      for (int w = 0; w < Ways; w++) begin
        if (!shadow_valid[base+w]) begin
          way = w;
          break;
        end
        other = shadow_tile[base+w] != tile;
        age = use_stamp - shadow_use[base+w];
        if (!have || (other && !best_other) || (other == best_other && age > best_age)) begin
          have = 1;
          way = w;
          best_other = other;
          best_age = age;
        end
      end
      idx = base + way;
      shadow_tag[idx] = tag;
      shadow_valid[idx] = 1;
      shadow_dirty[idx] = wr;
      shadow_use[idx] = use_stamp;
      shadow_tile[idx] = tile;
      misses_seen++;
    end
    use_stamp++;
    r.hit = found;
    r.way = way[WayOutW-1:0];
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  // Send one access and record its expected outcome on transfer.
  // Valid stays high after a transfer until the next access or an idle cycle.
  task automatic send_access(logic [AddrW-1:0] addr, logic wr);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_address <= addr;
    in_is_write <= wr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_lookups.push_back(predict_lookup(addr, wr));
  endtask

  // Builds an address from set, tag and offset within the line.
  function automatic logic [AddrW-1:0] make_addr(int unsigned set_idx,
                                                 logic [AddrW-1:0] tag);
    return (tag << (OffW + SetW)) | (AddrW'(set_idx) << OffW) |
           AddrW'($urandom_range(LineB-1));
  endfunction

  // Stop offering and wait until every expected result has come.
  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n || hold_out) out_ready <= 0;
    else out_ready <= !(idle_pct != 0 && $urandom_range(99) < idle_pct);
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    lookup_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result hit=%0d way=%0d", $time, out_hit, out_way);
        errors++;
      end else begin
        e = pending_lookups.pop_front();
        if (out_hit !== e.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_hit);
          errors++;
        end
        if (out_way !== e.way) begin
          $display("%0t: way expected %0d actual %0d", $time, e.way, out_way);
          errors++;
        end
        if (out_hit_total !== e.hit_total) begin
          $display("%0t: hit_total expected %0d actual %0d", $time, e.hit_total,
                   out_hit_total);
          errors++;
        end
        if (out_miss_total !== e.miss_total) begin
          $display("%0t: miss_total expected %0d actual %0d", $time, e.miss_total,
                   out_miss_total);
          errors++;
        end
      end
    end
  end

  // Extremes of the address, both access kinds, fill, hit and eviction.
  task automatic test_directed();
    idle_pct = 0;
    send_access('0, 1'b0);
    send_access('1, 1'b1);
    send_access('0, 1'b1);
    send_access(64'h8000_0000_0000_0000, 1'b0);
    send_access(64'h5555_5555_5555_5555, 1'b1);
    send_access(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    // Fill set 3 past capacity with tags of different tiles, then hit the last tag.
    for (int t = 0; t < Ways + 2; t++) send_access(make_addr(3, AddrW'(t)), t[0]);
    send_access(make_addr(3, AddrW'(9)), 1'b0);
    // Tile wrap: same tile index modulo 2^32, different tags.
    send_access(64'h0000_1000_0000_0000 | make_addr(3, AddrW'(1)), 1'b0);
    wait_drained();
  endtask

  // Mostly accesses within a few sets and tags so hits and evictions occur.
  task automatic test_random(int unsigned count);
    logic [AddrW-1:0] a;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) idle_pct = 0;
      if (n == count * 3 / 4) idle_pct = 11;
      if ($urandom_range(9) < 8)
        a = make_addr($urandom_range(3), AddrW'($urandom_range(11))) |
            (AddrW'($urandom_range(1)) << 40);
      else
        a = {$urandom, $urandom};
      send_access(a, 1'($urandom_range(1)));
    end
  endtask

  // Long receiver stall so the input queue fills, then sender pause.
  task automatic test_backpressure();
    fork
      begin
        hold_out = 1;
        repeat (200) @(posedge clk);
        hold_out = 0;
      end
      for (int n = 0; n < 20; n++)
        send_access(make_addr(5, AddrW'($urandom_range(9))), 1'b1);
    join
    wait_drained();
  endtask

  initial begin
    int unsigned guard;
    errors = 0;
    idle_pct = 11;
    hold_out = 0;
    use_stamp = 0;
    hits_seen = 0;
    misses_seen = 0;
    for (int i = 0; i < Sets * Ways; i++) begin
      shadow_valid[i] = 0;
      shadow_dirty[i] = 0;
      shadow_tag[i] = 0;
      shadow_use[i] = 0;
      shadow_tile[i] = 0;
    end
    rst_n = 0;
    in_valid = 0;
    in_address = '0;
    in_is_write = 0;
    out_ready = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    test_directed();
    idle_pct = 11;
    test_random(280);
    test_backpressure();
    idle_pct = 11;
    test_random(280);
    in_valid <= 0;
    guard = 0;
    while (pending_lookups.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
